/* sv/rcfk_pkg.sv */
// Shared constants, types and helper functions of the revolute chain kinematics block.
package rcfk_pkg;

   localparam int MAX_JOINTS   = 8;
   localparam int FRAME_WORDS  = 12;
   localparam int FRM_DEPTH    = (MAX_JOINTS + 1) * FRAME_WORDS;
   localparam int JNT_DEPTH    = MAX_JOINTS * FRAME_WORDS;
   localparam int FRM_AW       = $clog2(FRM_DEPTH);
   localparam int JNT_AW       = $clog2(JNT_DEPTH);
   localparam int JNT_W        = $clog2(MAX_JOINTS);
   localparam int CNT_W        = $clog2(MAX_JOINTS + 1);
   localparam int CORDIC_STEPS = 16;

   localparam logic signed [23:0] CORDIC_GAIN = 24'sd39797;
   localparam logic signed [23:0] ANG_PI      = 24'sd205887;
   localparam logic signed [23:0] ANG_HALF_PI = 24'sd102944;
   localparam logic signed [23:0] ANG_TWO_PI  = 24'sd411775;
   localparam logic signed [31:0] Q_ONE       = 32'sd65536;

   localparam logic [1:0] CMD_LOAD  = 2'd0;
   localparam logic [1:0] CMD_SET   = 2'd1;
   localparam logic [1:0] CMD_QUERY = 2'd2;

   typedef logic signed [31:0] word_type;

   function automatic logic signed [23:0] atan_step(input logic [3:0] i);
      logic signed [23:0] v;
      case (i)
         4'd0:    v = 24'sd51472;
         4'd1:    v = 24'sd30385;
         4'd2:    v = 24'sd16055;
         4'd3:    v = 24'sd8150;
         4'd4:    v = 24'sd4091;
         4'd5:    v = 24'sd2047;
         4'd6:    v = 24'sd1024;
         4'd7:    v = 24'sd512;
         4'd8:    v = 24'sd256;
         4'd9:    v = 24'sd128;
         4'd10:   v = 24'sd64;
         4'd11:   v = 24'sd32;
         4'd12:   v = 24'sd16;
         4'd13:   v = 24'sd8;
         4'd14:   v = 24'sd4;
         default: v = 24'sd2;
      endcase
      return v;
   endfunction

   // First word address of a twelve-word frame.
   function automatic logic [FRM_AW-1:0] frame_base(input logic [FRM_AW-1:0] k);
      return (k << 3) + (k << 2);
   endfunction

   function automatic word_type sat32(input logic signed [50:0] v);
      word_type r;
      if (v > 51'sd2147483647) begin
         r = 32'sh7fffffff;
      end else if (v < -51'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

/* sv/rcfk_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module rcfk_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 96
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end
endmodule

/* sv/revolute_chain_forward_kinematics_top.sv */
// Top level of the revolute chain forward kinematics engine.
//
//  Channel   Handshake              Contents
//  -------   ---------------------  ------------------------------------------
//  req_      start / busy           command, slot, element, word, joint, angle, point
//  rsp_      rsp_valid strobe       mapped_x, mapped_y, mapped_z (query only)
//  csr_      csr_valid / csr_ready  joints_in_use
//
// A transfer on the request channel happens at a clock edge with start high and busy low.
// A load writes the frame RAM directly and leaves busy low. A set-angle recomputes joints
// j..n-1 with a 16-step CORDIC, two 3x4 compositions on the one shared 32x32 multiplier,
// and twelve-word frame moves through the single read port of each frame RAM. A query
// uses the same multiplier (three four-term dot products per pass) and two frame reads.
// Reset is synchronous and active high; it clears the angles and sets the joint count to 8.
// The frame RAMs hold garbage until written. The result strobe lasts one cycle and cannot
// be stalled by the receiver; csr writes are always ready.
module revolute_chain_forward_kinematics_top
   import rcfk_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [1:0]          req_command,
   input  logic [3:0]          req_table_slot,
   input  logic [3:0]          req_element_index,
   input  logic signed [31:0]  req_word_value,
   input  logic [2:0]          req_joint_index,
   input  logic signed [15:0]  req_angle,
   input  logic signed [31:0]  req_point_x,
   input  logic signed [31:0]  req_point_y,
   input  logic signed [31:0]  req_point_z,
   output logic                rsp_valid,
   output logic signed [31:0]  rsp_mapped_x,
   output logic signed [31:0]  rsp_mapped_y,
   output logic signed [31:0]  rsp_mapped_z,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [3:0]          csr_joints_in_use
);

   // Sequencer states.
   localparam logic [3:0] ST_IDLE    = 4'd0;
   localparam logic [3:0] ST_SET_LDA = 4'd1;
   localparam logic [3:0] ST_CINIT   = 4'd2;
   localparam logic [3:0] ST_CORD    = 4'd3;
   localparam logic [3:0] ST_RZ      = 4'd4;
   localparam logic [3:0] ST_COMP1   = 4'd5;
   localparam logic [3:0] ST_WRS     = 4'd6;
   localparam logic [3:0] ST_LDL     = 4'd7;
   localparam logic [3:0] ST_COMP2   = 4'd8;
   localparam logic [3:0] ST_WRE     = 4'd9;
   localparam logic [3:0] ST_Q_LDA   = 4'd10;
   localparam logic [3:0] ST_Q_LDB   = 4'd11;
   localparam logic [3:0] ST_APPLY   = 4'd12;
   localparam logic [3:0] ST_TINV    = 4'd13;
   localparam logic [3:0] ST_MAP     = 4'd14;

   // Control registers.
   logic [3:0]        state_ff, state_in;
   logic [3:0]        w_ff, w_in;        // frame move word counter
   logic [3:0]        e_ff, e_in;        // result element counter
   logic [2:0]        mcnt_ff, mcnt_in;  // step within one dot product
   logic [3:0]        ci_ff, ci_in;      // CORDIC step
   logic [JNT_W-1:0]  j_ff, j_in;
   logic [JNT_W-1:0]  link_ff, link_in;
   logic [3:0]        cfg_ff, cfg_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic signed [15:0] ang_ff [MAX_JOINTS];
   logic signed [15:0] ang_in [MAX_JOINTS];

   // Datapath registers.
   word_type a_ff [FRAME_WORDS];
   word_type a_in [FRAME_WORDS];
   word_type b_ff [FRAME_WORDS];
   word_type b_in [FRAME_WORDS];
   word_type t_ff [FRAME_WORDS];
   word_type t_in [FRAME_WORDS];
   word_type at_ff [3];
   word_type at_in [3];
   word_type p_ff [3];
   word_type p_in [3];
   word_type q_ff [3];
   word_type q_in [3];
   word_type ti_ff [3];
   word_type ti_in [3];
   logic signed [63:0] prod_ff, prod_in;
   logic signed [49:0] acc_ff, acc_in;
   logic signed [23:0] cx_ff, cx_in, cy_ff, cy_in, cz_ff, cz_in;
   logic               flip_ff, flip_in;
   word_type           mx_ff, mx_in, my_ff, my_in, mz_ff, mz_in;

   // RAM interface.
   logic [FRM_AW-1:0] rd_addr, wr_addr, ld_base, frm_waddr;
   word_type          frm_rdata, str_rdata, end_rdata, ld_data;
   logic              frm_we, str_we, end_we;
   word_type          jwdata;

   // Combinational helpers.
   logic              accept;
   logic [CNT_W-1:0]  n_joints;
   logic [JNT_W-1:0]  last_j;
   logic              is_loader, is_mac, is_comp;
   logic [3:0]        ld_idx;
   logic [1:0]        r_i, c_i, tt, tidx;
   logic [3:0]        a_idx;
   word_type          mul_a, mul_b, res;
   logic signed [63:0] rnd_full;
   logic signed [49:0] rnd_w;
   logic              last_e;
   logic signed [23:0] z0, z1, dx, dy;
   logic signed [15:0] cur_ang;

   assign busy      = (state_ff != ST_IDLE);
   assign accept    = start && !busy;
   assign csr_ready = 1'b1;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_mapped_x = mx_ff;
   assign rsp_mapped_y = my_ff;
   assign rsp_mapped_z = mz_ff;

   // Joint count: zero acts as one, values past the table size clamp to it.
   always_comb begin
      if (cfg_ff == 4'd0) begin
         n_joints = CNT_W'(1);
      end else if (CNT_W'(cfg_ff) > CNT_W'(MAX_JOINTS) || cfg_ff > 4'(MAX_JOINTS)) begin
         n_joints = CNT_W'(MAX_JOINTS);
      end else begin
         n_joints = CNT_W'(cfg_ff);
      end
   end
   assign last_j = JNT_W'(n_joints - CNT_W'(1));

   // Frame read source: each twelve-word move reads one RAM, selected by state.
   always_comb begin
      ld_base = '0;
      ld_data = frm_rdata;
      case (state_ff)
         ST_SET_LDA: begin
            if (j_ff == '0) begin
               ld_base = '0;
               ld_data = frm_rdata;
            end else begin
               ld_base = frame_base(FRM_AW'(j_ff) - FRM_AW'(1));
               ld_data = end_rdata;
            end
         end
         ST_LDL: begin
            ld_base = frame_base(FRM_AW'(j_ff) + FRM_AW'(1));
            ld_data = frm_rdata;
         end
         ST_Q_LDA: begin
            ld_base = frame_base(FRM_AW'(link_ff));
            ld_data = str_rdata;
         end
         ST_Q_LDB: begin
            ld_base = frame_base(FRM_AW'(last_j));
            ld_data = end_rdata;
         end
         default: begin
            ld_base = '0;
            ld_data = frm_rdata;
         end
      endcase
   end

   assign rd_addr = ld_base + ((w_ff < 4'd12) ? FRM_AW'(w_ff) : FRM_AW'(0));
   assign wr_addr = frame_base(FRM_AW'(j_ff)) + FRM_AW'(w_ff);
   assign ld_idx  = w_ff - 4'd1;

   assign frm_we = accept && (req_command == CMD_LOAD)
                   && (req_table_slot <= 4'(MAX_JOINTS)) && (req_element_index < 4'd12);
   assign frm_waddr = frame_base(FRM_AW'(req_table_slot)) + FRM_AW'(req_element_index);
   assign str_we = (state_ff == ST_WRS);
   assign end_we = (state_ff == ST_WRE);
   assign jwdata = t_ff[(w_ff < 4'd12) ? w_ff : 4'd0];

   rcfk_ram #(.WIDTH(32), .DEPTH(FRM_DEPTH)) u_frame_ram (
      .clock (clock),
      .we    (frm_we),
      .waddr (frm_waddr),
      .wdata (req_word_value),
      .raddr (rd_addr),
      .rdata (frm_rdata)
   );

   rcfk_ram #(.WIDTH(32), .DEPTH(JNT_DEPTH)) u_start_ram (
      .clock (clock),
      .we    (str_we),
      .waddr (wr_addr[JNT_AW-1:0]),
      .wdata (jwdata),
      .raddr (rd_addr[JNT_AW-1:0]),
      .rdata (str_rdata)
   );

   rcfk_ram #(.WIDTH(32), .DEPTH(JNT_DEPTH)) u_end_ram (
      .clock (clock),
      .we    (end_we),
      .waddr (wr_addr[JNT_AW-1:0]),
      .wdata (jwdata),
      .raddr (rd_addr[JNT_AW-1:0]),
      .rdata (end_rdata)
   );

   // Shared multiply-accumulate: every result element is a four-term dot product.
   // The fourth term folds in a translation, if any, by multiplying it with 1.0, which is exact.
   assign is_loader = (state_ff == ST_SET_LDA) || (state_ff == ST_LDL)
                      || (state_ff == ST_Q_LDA) || (state_ff == ST_Q_LDB);
   assign is_comp   = (state_ff == ST_COMP1) || (state_ff == ST_COMP2);
   assign is_mac    = is_comp || (state_ff == ST_APPLY) || (state_ff == ST_TINV)
                      || (state_ff == ST_MAP);
   assign r_i  = is_comp ? e_ff[3:2] : e_ff[1:0];
   assign c_i  = e_ff[1:0];
   assign tt   = mcnt_ff[1:0];
   assign tidx = (tt == 2'd3) ? 2'd0 : tt;

   always_comb begin
      a_idx = {r_i, tt};
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_COMP1, ST_COMP2: begin
            a_idx = {r_i, tt};
            mul_a = a_ff[a_idx];
            if (tt != 2'd3) begin
               mul_b = b_ff[{tt, c_i}];
            end else begin
               mul_b = (c_i == 2'd3) ? Q_ONE : '0;
            end
         end
         ST_APPLY: begin
            a_idx = {r_i, tt};
            mul_a = b_ff[a_idx];
            mul_b = (tt == 2'd3) ? Q_ONE : p_ff[tidx];
         end
         ST_TINV: begin
            a_idx = (tt == 2'd3) ? 4'd0 : {tidx, r_i};
            mul_a = a_ff[a_idx];
            mul_b = (tt == 2'd3) ? '0 : at_ff[tidx];
         end
         ST_MAP: begin
            a_idx = (tt == 2'd3) ? 4'd0 : {tidx, r_i};
            mul_a = (tt == 2'd3) ? ti_ff[r_i] : a_ff[a_idx];
            mul_b = (tt == 2'd3) ? Q_ONE : q_ff[tidx];
         end
         default: begin
            a_idx = 4'd0;
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // Round to nearest, ties toward plus infinity, as an add and arithmetic shift.
   assign rnd_full = (prod_ff + 64'sd32768) >>> 16;
   assign rnd_w    = rnd_full[49:0];
   assign res      = (state_ff == ST_TINV) ? sat32(-{acc_ff[49], acc_ff})
                                           : sat32({acc_ff[49], acc_ff});
   assign last_e   = is_comp ? (e_ff == 4'd11) : (e_ff == 4'd2);

   // CORDIC angle reduction into [-pi/2, pi/2] with an output flip.
   assign cur_ang = ang_ff[j_ff];
   assign z0 = {{4{cur_ang[15]}}, cur_ang, 4'b0000};
   always_comb begin
      if (z0 > ANG_PI) begin
         z1 = z0 - ANG_TWO_PI;
      end else if (z0 < -ANG_PI) begin
         z1 = z0 + ANG_TWO_PI;
      end else begin
         z1 = z0;
      end
   end
   assign dx = cy_ff >>> ci_ff;
   assign dy = cx_ff >>> ci_ff;

   // Next-state and datapath update.
   always_comb begin
      state_in     = state_ff;
      w_in         = w_ff;
      e_in         = e_ff;
      mcnt_in      = mcnt_ff;
      ci_in        = ci_ff;
      j_in         = j_ff;
      link_in      = link_ff;
      rsp_valid_in = 1'b0;
      cfg_in       = (csr_valid && csr_ready) ? csr_joints_in_use : cfg_ff;
      ang_in       = ang_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      t_in         = t_ff;
      at_in        = at_ff;
      p_in         = p_ff;
      q_in         = q_ff;
      ti_in        = ti_ff;
      prod_in      = prod_ff;
      acc_in       = acc_ff;
      cx_in        = cx_ff;
      cy_in        = cy_ff;
      cz_in        = cz_ff;
      flip_in      = flip_ff;
      mx_in        = mx_ff;
      my_in        = my_ff;
      mz_in        = mz_ff;

      // Twelve-word frame moves into the A or B operand bank.
      if (is_loader) begin
         if (w_ff != 4'd0) begin
            if ((state_ff == ST_SET_LDA) || (state_ff == ST_Q_LDA)) begin
               a_in[ld_idx] = ld_data;
               if (ld_idx[1:0] == 2'd3) begin
                  at_in[ld_idx[3:2]] = ld_data;
               end
            end else begin
               b_in[ld_idx] = ld_data;
            end
         end
         if (w_ff == 4'd12) begin
            w_in = 4'd0;
         end else begin
            w_in = w_ff + 4'd1;
         end
      end

      if (is_mac) begin
         if (mcnt_ff < 3'd4) begin
            prod_in = mul_a * mul_b;
         end
         if (mcnt_ff == 3'd1) begin
            acc_in = rnd_w;
         end else if (mcnt_ff != 3'd0 && mcnt_ff != 3'd5) begin
            acc_in = acc_ff + rnd_w;
         end
         if (mcnt_ff == 3'd5) begin
            mcnt_in = 3'd0;
            e_in    = last_e ? 4'd0 : e_ff + 4'd1;
            case (state_ff)
               ST_COMP1, ST_COMP2: t_in[e_ff] = res;
               ST_APPLY:           q_in[r_i]  = res;
               ST_TINV:            ti_in[r_i] = res;
               default: begin
                  case (r_i)
                     2'd0:    mx_in = res;
                     2'd1:    my_in = res;
                     default: mz_in = res;
                  endcase
               end
            endcase
         end else begin
            mcnt_in = mcnt_ff + 3'd1;
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_command)
                  CMD_SET: begin
                     ang_in[req_joint_index] = req_angle;
                     if (CNT_W'(req_joint_index) < n_joints) begin
                        j_in     = req_joint_index;
                        w_in     = 4'd0;
                        state_in = ST_SET_LDA;
                     end
                  end
                  CMD_QUERY: begin
                     link_in  = (CNT_W'(req_joint_index) < n_joints) ? req_joint_index
                                                                     : last_j;
                     p_in[0]  = req_point_x;
                     p_in[1]  = req_point_y;
                     p_in[2]  = req_point_z;
                     w_in     = 4'd0;
                     state_in = ST_Q_LDA;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_SET_LDA: begin
            if (w_ff == 4'd12) begin
               state_in = ST_CINIT;
            end
         end
         ST_CINIT: begin
            cx_in = CORDIC_GAIN;
            cy_in = '0;
            ci_in = 4'd0;
            if (z1 > ANG_HALF_PI) begin
               cz_in   = z1 - ANG_PI;
               flip_in = 1'b1;
            end else if (z1 < -ANG_HALF_PI) begin
               cz_in   = z1 + ANG_PI;
               flip_in = 1'b1;
            end else begin
               cz_in   = z1;
               flip_in = 1'b0;
            end
            state_in = ST_CORD;
         end
         ST_CORD: begin
            if (cz_ff >= 24'sd0) begin
               cx_in = cx_ff - dx;
               cy_in = cy_ff + dy;
               cz_in = cz_ff - atan_step(ci_ff);
            end else begin
               cx_in = cx_ff + dx;
               cy_in = cy_ff - dy;
               cz_in = cz_ff + atan_step(ci_ff);
            end
            if (ci_ff == 4'(CORDIC_STEPS - 1)) begin
               state_in = ST_RZ;
            end else begin
               ci_in = ci_ff + 4'd1;
            end
         end
         ST_RZ: begin
            // Rotation about z, written into the B operand bank.
            for (int k = 0; k < FRAME_WORDS; k++) begin
               b_in[k] = '0;
            end
            if (flip_ff) begin
               b_in[0] = -{{8{cx_ff[23]}}, cx_ff};
               b_in[1] = {{8{cy_ff[23]}}, cy_ff};
               b_in[4] = -{{8{cy_ff[23]}}, cy_ff};
               b_in[5] = -{{8{cx_ff[23]}}, cx_ff};
            end else begin
               b_in[0] = {{8{cx_ff[23]}}, cx_ff};
               b_in[1] = -{{8{cy_ff[23]}}, cy_ff};
               b_in[4] = {{8{cy_ff[23]}}, cy_ff};
               b_in[5] = {{8{cx_ff[23]}}, cx_ff};
            end
            b_in[10] = Q_ONE;
            mcnt_in  = 3'd0;
            e_in     = 4'd0;
            state_in = ST_COMP1;
         end
         ST_COMP1: begin
            if (mcnt_ff == 3'd5 && last_e) begin
               w_in     = 4'd0;
               state_in = ST_WRS;
            end
         end
         ST_WRS, ST_WRE: begin
            if (w_ff == 4'd11) begin
               w_in = 4'd0;
               a_in = t_ff;
               at_in[0] = t_ff[3];
               at_in[1] = t_ff[7];
               at_in[2] = t_ff[11];
               if (state_ff == ST_WRS) begin
                  state_in = ST_LDL;
               end else if (CNT_W'(j_ff) + CNT_W'(1) < n_joints) begin
                  j_in     = j_ff + JNT_W'(1);
                  state_in = ST_CINIT;
               end else begin
                  state_in = ST_IDLE;
               end
            end else begin
               w_in = w_ff + 4'd1;
            end
         end
         ST_LDL: begin
            if (w_ff == 4'd12) begin
               state_in = ST_COMP2;
            end
         end
         ST_COMP2: begin
            if (mcnt_ff == 3'd5 && last_e) begin
               w_in     = 4'd0;
               state_in = ST_WRE;
            end
         end
         ST_Q_LDA: begin
            if (w_ff == 4'd12) begin
               state_in = ST_Q_LDB;
            end
         end
         ST_Q_LDB: begin
            if (w_ff == 4'd12) begin
               state_in = ST_APPLY;
            end
         end
         ST_APPLY: begin
            if (mcnt_ff == 3'd5 && last_e) begin
               state_in = ST_TINV;
            end
         end
         ST_TINV: begin
            if (mcnt_ff == 3'd5 && last_e) begin
               state_in = ST_MAP;
            end
         end
         ST_MAP: begin
            if (mcnt_ff == 3'd5 && last_e) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state, cleared by reset but for the joint count, which resets to the full chain.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         w_ff         <= '0;
         e_ff         <= '0;
         mcnt_ff      <= '0;
         ci_ff        <= '0;
         j_ff         <= '0;
         link_ff      <= '0;
         cfg_ff       <= 4'(MAX_JOINTS);
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < MAX_JOINTS; k++) begin
            ang_ff[k] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         w_ff         <= w_in;
         e_ff         <= e_in;
         mcnt_ff      <= mcnt_in;
         ci_ff        <= ci_in;
         j_ff         <= j_in;
         link_ff      <= link_in;
         cfg_ff       <= cfg_in;
         rsp_valid_ff <= rsp_valid_in;
         ang_ff       <= ang_in;
      end
   end

   // Datapath registers carry no reset.
   always_ff @(posedge clock) begin
      a_ff    <= a_in;
      b_ff    <= b_in;
      t_ff    <= t_in;
      at_ff   <= at_in;
      p_ff    <= p_in;
      q_ff    <= q_in;
      ti_ff   <= ti_in;
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      cx_ff   <= cx_in;
      cy_ff   <= cy_in;
      cz_ff   <= cz_in;
      flip_ff <= flip_in;
      mx_ff   <= mx_in;
      my_ff   <= my_in;
      mz_ff   <= mz_in;
   end

endmodule

/* bench/tb.sv */
// Testbench for the revolute chain forward kinematics block: directed and random commands.
`timescale 1ns / 100ps

module tb;
   import rcfk_pkg::*;

   // The clock period is 8 ns. The limit sits far above what a run made only of full-chain
   // updates under the longest gaps needs.
   localparam int CYCLE_LIMIT = 10000000;
   // Pause before a joint-count write. A set on the full chain produces no result that
   // would tell us it has finished.
   localparam int SETTLE_CYCLES = 2000;
   // The one command code that the block ignores.
   localparam logic [1:0] CMD_SPARE = 2'd3;

   typedef word_type frame_type [FRAME_WORDS];
   typedef struct {
      word_type x;
      word_type y;
      word_type z;
   } point_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [1:0] req_command = CMD_LOAD;
   logic [3:0] req_table_slot = '0;
   logic [3:0] req_element_index = '0;
   logic signed [31:0] req_word_value = '0;
   logic [2:0] req_joint_index = '0;
   logic signed [15:0] req_angle = '0;
   logic signed [31:0] req_point_x = '0;
   logic signed [31:0] req_point_y = '0;
   logic signed [31:0] req_point_z = '0;
   logic rsp_valid;
   logic signed [31:0] rsp_mapped_x;
   logic signed [31:0] rsp_mapped_y;
   logic signed [31:0] rsp_mapped_z;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [3:0] csr_joints_in_use = 4'd8;

   revolute_chain_forward_kinematics_top dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_command(req_command), .req_table_slot(req_table_slot),
      .req_element_index(req_element_index), .req_word_value(req_word_value),
      .req_joint_index(req_joint_index), .req_angle(req_angle),
      .req_point_x(req_point_x), .req_point_y(req_point_y), .req_point_z(req_point_z),
      .rsp_valid(rsp_valid), .rsp_mapped_x(rsp_mapped_x), .rsp_mapped_y(rsp_mapped_y),
      .rsp_mapped_z(rsp_mapped_z), .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_joints_in_use(csr_joints_in_use)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Shadow state of the chain, kept in step with every accepted transfer.
   frame_type link_table [MAX_JOINTS + 1];
   frame_type start_pose [MAX_JOINTS];
   frame_type end_pose [MAX_JOINTS];
   logic signed [15:0] joint_angle [MAX_JOINTS];
   logic [3:0] joint_count_reg;

   // Mapped points still owed by the block, oldest first.
   point_type mapped_q [$];

   int mismatches = 0;
   int cycles = 0;
   int loads_sent = 0;
   int sets_sent = 0;
   int queries_sent = 0;
   int results_seen = 0;
   bit gaps_on = 1'b1;

   function automatic longint qmul(word_type a, word_type b);
      longint p;
      p = longint'(a) * longint'(b) + 64'sd32768;
      return p >>> 16;
   endfunction

   function automatic word_type clamp32(longint v);
      if (v > 64'sd2147483647) begin
         return 32'sh7fffffff;
      end
      if (v < -64'sd2147483648) begin
         return 32'sh80000000;
      end
      return word_type'(v);
   endfunction

   function automatic int chain_joints();
      if (joint_count_reg == 0) begin
         return 1;
      end
      if (joint_count_reg > MAX_JOINTS) begin
         return MAX_JOINTS;
      end
      return int'(joint_count_reg);
   endfunction

   function automatic frame_type compose(frame_type a, frame_type b);
      frame_type o;
      longint acc;
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 4; c++) begin
            acc = qmul(a[r*4], b[c]) + qmul(a[r*4+1], b[4+c]) + qmul(a[r*4+2], b[8+c]);
            if (c == 3) begin
               acc += longint'(a[r*4+3]);
            end
            o[r*4+c] = clamp32(acc);
         end
      end
      return o;
   endfunction

   function automatic point_type transform(frame_type m, point_type p);
      point_type o;
      word_type v [3];
      longint acc;
      for (int r = 0; r < 3; r++) begin
         acc = qmul(m[r*4], p.x) + qmul(m[r*4+1], p.y) + qmul(m[r*4+2], p.z)
               + longint'(m[r*4+3]);
         v[r] = clamp32(acc);
      end
      o.x = v[0];
      o.y = v[1];
      o.z = v[2];
      return o;
   endfunction

   // Rotation-mode CORDIC after folding the angle into the right half plane.
   function automatic void cordic_sin_cos(logic signed [15:0] ang, output word_type c,
                                          output word_type s);
      longint z, x, y, dx, dy;
      bit flip;
      z = longint'(ang) * 16;
      x = 39797;
      y = 0;
      flip = 1'b0;
      while (z > 205887) z -= 411775;
      while (z < -205887) z += 411775;
      if (z > 102944) begin
         z -= 205887;
         flip = 1'b1;
      end else if (z < -102944) begin
         z += 205887;
         flip = 1'b1;
      end
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x -= dx;
            y += dy;
            z -= longint'(atan_step(4'(i)));
         end else begin
            x += dx;
            y -= dy;
            z += longint'(atan_step(4'(i)));
         end
      end
      if (flip) begin
         x = -x;
         y = -y;
      end
      c = word_type'(x);
      s = word_type'(y);
   endfunction

   function automatic void update_chain(int first);
      frame_type rz;
      word_type c, s;
      for (int j = first; j < chain_joints(); j++) begin
         cordic_sin_cos(joint_angle[j], c, s);
         rz = '{default: '0};
         rz[0] = c;
         rz[1] = clamp32(-longint'(s));
         rz[4] = s;
         rz[5] = c;
         rz[10] = Q_ONE;
         start_pose[j] = compose((j == 0) ? link_table[0] : end_pose[j-1], rz);
         end_pose[j] = compose(start_pose[j], link_table[j+1]);
      end
   endfunction

   function automatic point_type map_to_link(int jidx, point_type p);
      frame_type inv;
      frame_type sf;
      int n, link;
      n = chain_joints();
      link = (jidx < n) ? jidx : n - 1;
      sf = start_pose[link];
      for (int k = 0; k < 3; k++) begin
         for (int c = 0; c < 3; c++) begin
            inv[k*4+c] = sf[c*4+k];
         end
         inv[k*4+3] = clamp32(-(qmul(sf[k], sf[3]) + qmul(sf[4+k], sf[7])
                               + qmul(sf[8+k], sf[11])));
      end
      return transform(inv, transform(end_pose[n-1], p));
   endfunction

   // Applies one accepted command to the shadow state.
   function automatic void predict_command();
      point_type p;
      case (req_command)
         CMD_LOAD: begin
            loads_sent++;
            if (req_table_slot <= MAX_JOINTS && req_element_index < FRAME_WORDS) begin
               link_table[req_table_slot][req_element_index] = req_word_value;
            end
         end
         CMD_SET: begin
            sets_sent++;
            joint_angle[req_joint_index] = req_angle;
            update_chain(int'(req_joint_index));
         end
         CMD_QUERY: begin
            queries_sent++;
            p.x = req_point_x;
            p.y = req_point_y;
            p.z = req_point_z;
            mapped_q.push_back(map_to_link(int'(req_joint_index), p));
         end
         default: ;
      endcase
   endfunction

   function automatic word_type moderate_word();
      return word_type'($urandom_range(0, 262143)) - 32'sd131072;
   endfunction

   function automatic word_type any_word();
      return ($urandom_range(0, 3) == 0) ? word_type'($urandom) : moderate_word();
   endfunction

   // Sends one command. Every field is driven on every transfer, used or not.
   task automatic send_item(logic [1:0] cmd, logic [3:0] slot, logic [3:0] elem,
                            word_type word, logic [2:0] jidx, logic signed [15:0] ang,
                            word_type px, word_type py, word_type pz);
      if (gaps_on && $urandom_range(0, 99) < 23) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      start <= 1'b1;
      req_command <= cmd;
      req_table_slot <= slot;
      req_element_index <= elem;
      req_word_value <= word;
      req_joint_index <= jidx;
      req_angle <= ang;
      req_point_x <= px;
      req_point_y <= py;
      req_point_z <= pz;
      do @(posedge clock); while (busy);
      predict_command();
   endtask

   task automatic load_word(logic [3:0] slot, logic [3:0] elem, word_type word);
      send_item(CMD_LOAD, slot, elem, word, 3'($urandom), 16'($urandom), $urandom,
                $urandom, $urandom);
   endtask

   task automatic set_angle(logic [2:0] jidx, logic signed [15:0] ang);
      send_item(CMD_SET, 4'($urandom), 4'($urandom), $urandom, jidx, ang, $urandom,
                $urandom, $urandom);
   endtask

   task automatic query_point(logic [2:0] jidx, word_type px, word_type py, word_type pz);
      send_item(CMD_QUERY, 4'($urandom), 4'($urandom), $urandom, jidx, 16'($urandom),
                px, py, pz);
   endtask

   // Writes the joint count once the block has drained, including any silent set.
   task automatic write_joint_count(logic [3:0] count);
      start <= 1'b0;
      while (mapped_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_joints_in_use <= count;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      joint_count_reg = count;
   endtask

   // Fills every frame-table word with a moderate random value, then sets joint 0 so that
   // all start and end frames of the full chain are written before anything reads them.
   task automatic test_fill_chain();
      for (int slot = 0; slot <= MAX_JOINTS; slot++) begin
         for (int e = 0; e < FRAME_WORDS; e++) begin
            load_word(4'(slot), 4'(e), moderate_word());
         end
      end
      set_angle(3'd0, 16'sd0);
   endtask

   // Short directed pass over angle extremes, ignored commands and saturating values.
   task automatic test_directed();
      set_angle(3'd0, 16'sh7fff);
      set_angle(3'd7, 16'sh8000);
      set_angle(3'd3, 16'sd12868);     // about +pi
      set_angle(3'd2, -16'sd12868);    // about -pi
      set_angle(3'd5, 16'sd6434);      // about +pi/2
      set_angle(3'd6, -16'sd6434);
      query_point(3'd0, '0, '0, '0);
      query_point(3'd7, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff);
      query_point(3'd4, 32'sh80000000, 32'sh7fffffff, 32'sh80000000);
      // Loads outside the table or the frame leave the table alone.
      load_word(4'd9, 4'd0, 32'sh7fffffff);
      load_word(4'd15, 4'd3, 32'sh80000000);
      load_word(4'd1, 4'd12, 32'sh7fffffff);
      load_word(4'd1, 4'd15, 32'sh80000000);
      send_item(CMD_SPARE, 4'd0, 4'd0, 32'sh7fffffff, 3'd0, 16'sd100, '1, '1, '1);
      // Extreme table words force saturation in the compositions.
      load_word(4'd0, 4'd0, 32'sh7fffffff);
      load_word(4'd0, 4'd3, 32'sh80000000);
      load_word(4'd8, 4'd11, 32'sh7fffffff);
      set_angle(3'd0, 16'sd1000);
      query_point(3'd7, 32'sh00010000, 32'sh7fffffff, 32'sh80000000);
      query_point(3'd0, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
      load_word(4'd0, 4'd0, 32'sh00010000);
      load_word(4'd0, 4'd3, 32'sh00020000);
      load_word(4'd8, 4'd11, 32'sh00008000);
      set_angle(3'd0, 16'sd0);
   endtask

   // Random traffic, mostly queries and angle updates on top of a valid chain, with a
   // share of table reloads, out-of-range loads and the unused command as noise.
   task automatic test_random(int count);
      int pick;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 45) begin
            query_point(3'($urandom), any_word(), any_word(), any_word());
         end else if (pick < 75) begin
            set_angle(3'($urandom), 16'($urandom));
         end else if (pick < 90) begin
            load_word(4'($urandom_range(0, MAX_JOINTS)), 4'($urandom_range(0, 11)),
                      any_word());
         end else if (pick < 95) begin
            load_word(4'($urandom), 4'($urandom), $urandom);
         end else begin
            send_item(CMD_SPARE, 4'($urandom), 4'($urandom), $urandom, 3'($urandom),
                      16'($urandom), $urandom, $urandom, $urandom);
         end
      end
   endtask

   // Each result strobe is accepted at the edge that ends its cycle and checked against
   // the oldest owed point.
   always @(posedge clock) begin
      point_type want;
      if (!reset && rsp_valid) begin
         results_seen++;
         if (mapped_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("result with nothing owed: %h %h %h", rsp_mapped_x, rsp_mapped_y,
                        rsp_mapped_z);
            end
         end else begin
            want = mapped_q.pop_front();
            if (rsp_mapped_x !== want.x || rsp_mapped_y !== want.y
                || rsp_mapped_z !== want.z) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("mapped point mismatch: expected %h %h %h, got %h %h %h",
                           want.x, want.y, want.z, rsp_mapped_x, rsp_mapped_y,
                           rsp_mapped_z);
               end
            end
         end
      end
   end

   // Watchdog: a hung block ends the run here.
   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      for (int j = 0; j < MAX_JOINTS; j++) joint_angle[j] = '0;
      for (int s = 0; s <= MAX_JOINTS; s++) link_table[s] = '{default: '0};
      joint_count_reg = 4'd8;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_fill_chain();
      test_directed();

      // Walk the joint count through its extremes, including the out-of-range codes
      // that clamp to one and to the full chain. One phase runs with no gaps at all.
      write_joint_count(4'd8);
      test_random(150);
      write_joint_count(4'd1);
      test_random(140);
      write_joint_count(4'd0);
      test_random(100);
      write_joint_count(4'd15);
      gaps_on = 1'b0;
      test_random(150);
      gaps_on = 1'b1;
      write_joint_count(4'd3);
      test_random(150);
      write_joint_count(4'd5);
      test_random(150);
      write_joint_count(4'd8);
      test_random(160);

      start <= 1'b0;
      while (mapped_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("covered %0d loads, %0d angle sets, %0d queries; %0d points checked",
               loads_sent, sets_sent, queries_sent, results_seen);
      $display("joint counts 8, 1, 0, 15, 3, 5 applied; %0d mismatches", mismatches);
      if (mismatches == 0 && mapped_q.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

/* files.f */
sv/rcfk_pkg.sv
sv/rcfk_ram.sv
sv/revolute_chain_forward_kinematics_top.sv
bench/tb.sv
